### hdl/obb2d_separating_axis_test_core_defines.svh
//------------------------------------------------------------------------------
// OBB2D assertion macros
// Shared concurrent assertion forms for the box overlap core.
//------------------------------------------------------------------------------
`ifndef OBB2D_SEPARATING_AXIS_TEST_CORE_DEFINES_SVH
`define OBB2D_SEPARATING_AXIS_TEST_CORE_DEFINES_SVH

// antecedent implies consequent (consequent may start with a delay)
`define OBB2D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// condition must never hold
`define OBB2D_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### hdl/obb2d_pkg.sv
//------------------------------------------------------------------------------
// OBB2D package
// Shared constants, codes and types of the box overlap core.
//------------------------------------------------------------------------------
package obb2d_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int UA_LAT     = SQRT_STEPS + DIV_STEPS + 4;
   localparam int AT_LAT     = 5;
   localparam int TOTAL_LAT  = UA_LAT + AT_LAT;

   localparam logic [2:0] GAP_A_X  = 3'd0;
   localparam logic [2:0] GAP_A_Y  = 3'd1;
   localparam logic [2:0] GAP_B_X  = 3'd2;
   localparam logic [2:0] GAP_B_Y  = 3'd3;
   localparam logic [2:0] GAP_NONE = 3'd4;

   typedef logic signed [31:0] unit_type;

   typedef struct packed {
      unit_type x;
      unit_type y;
   } vec_type;

   typedef struct packed {
      logic [31:0] ha1;
      logic [31:0] ha2;
      logic [31:0] hb1;
      logic [31:0] hb2;
   } half_type;

   typedef struct packed {
      logic signed [32:0] dd_x;
      logic signed [32:0] dd_y;
      half_type           half;
   } side_type;

   typedef struct packed {
      vec_type  ua1;
      vec_type  ua2;
      vec_type  ub1;
      vec_type  ub2;
      side_type side;
   } boxes_type;

endpackage

### hdl/obb2d_isqrt.sv
//------------------------------------------------------------------------------
// OBB2D integer square root
// Pipelined digit-by-digit square root, one result bit per stage.
//------------------------------------------------------------------------------
module obb2d_isqrt
   import obb2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_radicand,
   output logic        out_valid,
   output logic [31:0] out_root
);

   logic [SQRT_STEPS:0] vld_ff;
   logic [SQRT_STEPS:0] vld_in;
   logic [63:0]         rem_ff [SQRT_STEPS+1];
   logic [63:0]         res_ff [SQRT_STEPS+1];

   assign vld_in = {vld_ff[SQRT_STEPS-1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= in_radicand;
      res_ff[0] <= '0;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      logic [63:0] rem_in;
      logic [63:0] res_in;

      always_comb begin
         trial = res_ff[k] + StepBit;
         if (rem_ff[k] >= trial) begin
            rem_in = rem_ff[k] - trial;
            res_in = (res_ff[k] >> 1) + StepBit;
         end else begin
            rem_in = rem_ff[k];
            res_in = res_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in;
         res_ff[k+1] <= res_in;
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS];
   assign out_root  = res_ff[SQRT_STEPS][31:0];

endmodule

### hdl/obb2d_div.sv
//------------------------------------------------------------------------------
// OBB2D axis divider
// Pipelined restoring divide of num * 2^30 by den, for num not above den.
//------------------------------------------------------------------------------
module obb2d_div
   import obb2d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [31:0]          in_num,
   input  logic [31:0]          in_den,
   output logic                 out_valid,
   output logic [DIV_STEPS-1:0] out_quo
);

   logic [DIV_STEPS-1:0] vld_ff;
   logic [DIV_STEPS-1:0] vld_in;
   logic [31:0]          rem_ff [DIV_STEPS];
   logic [31:0]          den_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS];
   logic                 ge0;

   assign vld_in = {vld_ff[DIV_STEPS-2:0], in_valid};
   assign ge0    = in_num >= in_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= ge0 ? (in_num - in_den) : in_num;
      den_ff[0] <= in_den;
      quo_ff[0] <= {{(DIV_STEPS-1){1'b0}}, ge0};
   end

   for (genvar k = 0; k < DIV_STEPS - 1; k++) begin : g_step
      logic [32:0] rem2;
      logic        ge;
      logic [31:0] rem_in;

      always_comb begin
         rem2   = {rem_ff[k], 1'b0};
         ge     = rem2 >= {1'b0, den_ff[k]};
         rem_in = ge ? 32'(rem2 - {1'b0, den_ff[k]}) : rem2[31:0];
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in;
         den_ff[k+1] <= den_ff[k];
         quo_ff[k+1] <= {quo_ff[k][DIV_STEPS-2:0], ge};
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_quo   = quo_ff[DIV_STEPS-1];

endmodule

### hdl/obb2d_unit_axis.sv
//------------------------------------------------------------------------------
// OBB2D unit axis
// Normalizes one matrix row to a Q2.30 unit direction, zero row to zero.
//------------------------------------------------------------------------------
module obb2d_unit_axis
   import obb2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_dx,
   input  logic [31:0] in_dy,
   output logic        out_valid,
   output vec_type     out_axis
);

   typedef struct packed {
      logic [31:0] ax;
      logic [31:0] ay;
      logic        sx;
      logic        sy;
   } mag_type;

   typedef struct packed {
      logic sx;
      logic sy;
      logic zero;
   } sign_type;

   logic                 v0_ff, v1_ff, v3_ff;
   logic                 v0_in;
   mag_type              m0_ff, m1_ff, m0_in;
   logic [63:0]          sqx_ff, sqy_ff;
   mag_type              md_ff [SQRT_STEPS+1];
   sign_type             sd_ff [DIV_STEPS];
   logic                 sq_valid;
   logic [31:0]          root;
   logic                 dv_valid;
   logic [DIV_STEPS-1:0] qx, qy;
   logic [31:0]          qx_ext, qy_ext;
   vec_type              axis_ff, axis_in;

   assign v0_in    = in_valid;
   assign m0_in.ax = in_dx[31] ? (~in_dx + 32'd1) : in_dx;
   assign m0_in.ay = in_dy[31] ? (~in_dy + 32'd1) : in_dy;
   assign m0_in.sx = in_dx[31];
   assign m0_in.sy = in_dy[31];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v0_ff;
         v3_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      m0_ff  <= m0_in;
      m1_ff  <= m0_ff;
      sqx_ff <= m0_ff.ax * m0_ff.ax;
      sqy_ff <= m0_ff.ay * m0_ff.ay;
      md_ff[0] <= m1_ff;
      for (int i = 1; i <= SQRT_STEPS; i++) begin
         md_ff[i] <= md_ff[i-1];
      end
      sd_ff[0] <= '{sx: md_ff[SQRT_STEPS].sx, sy: md_ff[SQRT_STEPS].sy, zero: root == '0};
      for (int i = 1; i < DIV_STEPS; i++) begin
         sd_ff[i] <= sd_ff[i-1];
      end
      axis_ff <= axis_in;
   end

   obb2d_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v1_ff),
      .in_radicand (sqx_ff + sqy_ff),
      .out_valid   (sq_valid),
      .out_root    (root)
   );

   obb2d_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_num    (md_ff[SQRT_STEPS].ax),
      .in_den    (root),
      .out_valid (dv_valid),
      .out_quo   (qx)
   );

   obb2d_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_num    (md_ff[SQRT_STEPS].ay),
      .in_den    (root),
      .out_valid (),
      .out_quo   (qy)
   );

   assign qx_ext = 32'(qx);
   assign qy_ext = 32'(qy);

   always_comb begin
      if (sd_ff[DIV_STEPS-1].zero) begin
         axis_in = '0;
      end else begin
         axis_in.x = sd_ff[DIV_STEPS-1].sx ? unit_type'(~qx_ext + 32'd1) : unit_type'(qx_ext);
         axis_in.y = sd_ff[DIV_STEPS-1].sy ? unit_type'(~qy_ext + 32'd1) : unit_type'(qy_ext);
      end
   end

   assign out_valid = v3_ff;
   assign out_axis  = axis_ff;

endmodule

### hdl/obb2d_axis_test.sv
//------------------------------------------------------------------------------
// OBB2D axis test
// Projects radii and centre distance on all four axes and picks the first gap.
//------------------------------------------------------------------------------
module obb2d_axis_test
   import obb2d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  boxes_type  in_boxes,
   output logic       out_valid,
   output logic       out_hit,
   output logic [2:0] out_gap
);

   vec_type            axis [4];
   logic [AT_LAT-1:0]  vld_ff, vld_in;

   logic signed [61:0] dp_ff [4][2];
   logic signed [64:0] xp_ff [4][2];
   half_type           h1_ff, h2_ff;

   logic [31:0]        dm_ff [4];
   logic [66:0]        d2_ff [4], d3_ff [4], d4_ff [4];
   logic [63:0]        op_ff [4][2];
   logic [61:0]        own_ff [4];
   logic [66:0]        lim_ff [4];

   logic [3:0]         sep;
   logic [2:0]         gap_in, gap_ff;
   logic               hit_ff;

   assign axis[0] = in_boxes.ua1;
   assign axis[1] = in_boxes.ua2;
   assign axis[2] = in_boxes.ub1;
   assign axis[3] = in_boxes.ub2;

   assign vld_in = {vld_ff[AT_LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         dp_ff[i][0] <= 62'(axis[i/2].x * axis[2 + (i % 2)].x);
         dp_ff[i][1] <= 62'(axis[i/2].y * axis[2 + (i % 2)].y);
         xp_ff[i][0] <= 65'(in_boxes.side.dd_x * 65'(axis[i].x));
         xp_ff[i][1] <= 65'(in_boxes.side.dd_y * 65'(axis[i].y));
      end
      h1_ff <= in_boxes.side.half;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         logic signed [62:0] ds;
         logic [62:0]        dmag;
         logic signed [65:0] xs;
         logic [65:0]        xmag;
         ds      = 63'(dp_ff[i][0]) + 63'(dp_ff[i][1]);
         dmag    = ds[62] ? 63'(-ds) : 63'(ds);
         dm_ff[i] <= dmag[61:30];
         xs      = 66'(xp_ff[i][0]) + 66'(xp_ff[i][1]);
         xmag    = xs[65] ? 66'(-xs) : 66'(xs);
         d2_ff[i] <= {xmag, 1'b0};
      end
      h2_ff <= h1_ff;
   end

   always_ff @(posedge clock) begin
      op_ff[0][0] <= dm_ff[0] * h2_ff.hb1;
      op_ff[0][1] <= dm_ff[1] * h2_ff.hb2;
      op_ff[1][0] <= dm_ff[2] * h2_ff.hb1;
      op_ff[1][1] <= dm_ff[3] * h2_ff.hb2;
      op_ff[2][0] <= dm_ff[0] * h2_ff.ha1;
      op_ff[2][1] <= dm_ff[2] * h2_ff.ha2;
      op_ff[3][0] <= dm_ff[1] * h2_ff.ha1;
      op_ff[3][1] <= dm_ff[3] * h2_ff.ha2;
      own_ff[0]   <= {h2_ff.ha1, 30'd0};
      own_ff[1]   <= {h2_ff.ha2, 30'd0};
      own_ff[2]   <= {h2_ff.hb1, 30'd0};
      own_ff[3]   <= {h2_ff.hb2, 30'd0};
      d3_ff       <= d2_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         lim_ff[i] <= 67'(own_ff[i]) + 67'(op_ff[i][0]) + 67'(op_ff[i][1]);
      end
      d4_ff <= d3_ff;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sep[i] = d4_ff[i] > lim_ff[i];
      end
      priority if (sep[0]) gap_in = GAP_A_X;
      else if (sep[1])     gap_in = GAP_A_Y;
      else if (sep[2])     gap_in = GAP_B_X;
      else if (sep[3])     gap_in = GAP_B_Y;
      else                 gap_in = GAP_NONE;
   end

   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
      hit_ff <= sep == 4'd0;
   end

   assign out_valid = vld_ff[AT_LAT-1];
   assign out_hit   = hit_ff;
   assign out_gap   = gap_ff;

endmodule

### hdl/obb2d_separating_axis_test_core.sv
//------------------------------------------------------------------------------
// OBB2D separating axis test core
// Overlap test of two 2D oriented boxes over four separating axes.
//------------------------------------------------------------------------------
// Usage:
//   Drive the twelve req_ fields (signed Q16.16) and raise start for one
//   cycle per box pair. busy stays low, so a transfer happens on every cycle
//   in which start is high; a new pair may follow in the very next cycle.
//   Each pair yields one result: rsp_valid pulses for one cycle with rsp_hit
//   and rsp_first_gap_axis (A-x, A-y, B-x, B-y, or none).
//   From start to rsp_valid the axes are normalized (32-step square root,
//   then 31-step divider), then projections, radius sums and the compare.
//   Throughput is one pair per cycle; results leave in transfer order.
//   The receiver has no hold-off: a result is taken in its strobe cycle.
//   Reset clears all valid bits; pairs in flight are dropped.
//------------------------------------------------------------------------------
`include "obb2d_separating_axis_test_core_defines.svh"

module obb2d_separating_axis_test_core
   import obb2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_a_x,
   input  logic [31:0] req_pos_a_y,
   input  logic [31:0] req_mat_a_11,
   input  logic [31:0] req_mat_a_12,
   input  logic [31:0] req_mat_a_21,
   input  logic [31:0] req_mat_a_22,
   input  logic [31:0] req_pos_b_x,
   input  logic [31:0] req_pos_b_y,
   input  logic [31:0] req_mat_b_11,
   input  logic [31:0] req_mat_b_12,
   input  logic [31:0] req_mat_b_21,
   input  logic [31:0] req_mat_b_22,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [2:0]  rsp_first_gap_axis
);

   logic      accept;
   side_type  side_in;
   side_type  side_ff [UA_LAT];
   vec_type   ua1, ua2, ub1, ub2;
   logic      axes_valid;
   boxes_type boxes;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   assign side_in.dd_x     = 33'(signed'(req_pos_a_x)) - 33'(signed'(req_pos_b_x));
   assign side_in.dd_y     = 33'(signed'(req_pos_a_y)) - 33'(signed'(req_pos_b_y));
   assign side_in.half.ha1 = mag32(req_mat_a_11);
   assign side_in.half.ha2 = mag32(req_mat_a_22);
   assign side_in.half.hb1 = mag32(req_mat_b_11);
   assign side_in.half.hb2 = mag32(req_mat_b_22);

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < UA_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   obb2d_unit_axis u_axis_a1 (
      .clock (clock), .reset (reset), .in_valid (accept),
      .in_dx (req_mat_a_11), .in_dy (req_mat_a_12),
      .out_valid (axes_valid), .out_axis (ua1)
   );

   obb2d_unit_axis u_axis_a2 (
      .clock (clock), .reset (reset), .in_valid (accept),
      .in_dx (req_mat_a_21), .in_dy (req_mat_a_22),
      .out_valid (), .out_axis (ua2)
   );

   obb2d_unit_axis u_axis_b1 (
      .clock (clock), .reset (reset), .in_valid (accept),
      .in_dx (req_mat_b_11), .in_dy (req_mat_b_12),
      .out_valid (), .out_axis (ub1)
   );

   obb2d_unit_axis u_axis_b2 (
      .clock (clock), .reset (reset), .in_valid (accept),
      .in_dx (req_mat_b_21), .in_dy (req_mat_b_22),
      .out_valid (), .out_axis (ub2)
   );

   assign boxes.ua1  = ua1;
   assign boxes.ua2  = ua2;
   assign boxes.ub1  = ub1;
   assign boxes.ub2  = ub2;
   assign boxes.side = side_ff[UA_LAT-1];

   obb2d_axis_test u_axis_test (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (axes_valid),
      .in_boxes  (boxes),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_gap   (rsp_first_gap_axis)
   );

   `OBB2D_ASSERT_IMP(a_hit_matches_gap, clock, reset, rsp_valid, (rsp_hit == (rsp_first_gap_axis == GAP_NONE)), "hit disagrees with first gap axis")
   `OBB2D_ASSERT_IMP(a_fixed_latency, clock, reset, accept, ##TOTAL_LAT rsp_valid, "result missing after pipeline latency")
   `OBB2D_ASSERT_NEVER(a_gap_code, clock, reset, (rsp_valid && (rsp_first_gap_axis > GAP_NONE)), "gap axis code out of range")

endmodule
